>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMSG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmsg check failed");

// next-cycle implication, disabled during reset
`define RMSG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmsg check failed");

`endif

>>> hdl/rmsg_pkg.sv
// shared constants and types of the rms level meter with gain
package rmsg_pkg;

   parameter int unsigned MAX_BLOCK_SAMPLES = 4096;

   parameter int unsigned SAMPLE_W   = 24;
   parameter int unsigned GAIN_W     = 16;
   parameter int unsigned GAIN_SHIFT = 14;
   parameter int unsigned LEVEL_W    = 24;

   // count holds 0..MAX_BLOCK_SAMPLES
   parameter int unsigned CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
   // a square is at most 2^46, the sum at most MAX * 2^46
   parameter int unsigned SQ_W   = 47;
   parameter int unsigned SUM_W  = 46 + CNT_W;
   // mean never exceeds 2^46, root taken over 48 bits
   parameter int unsigned MEAN_W = 2 * LEVEL_W;
   // shared compare-subtract width
   parameter int unsigned SUB_W  = LEVEL_W + 2;
   parameter int unsigned STEP_W = $clog2(SUM_W);

   parameter int unsigned MUL_W  = SAMPLE_W + 1;
   parameter int unsigned PROD_W = 2 * MUL_W;
   parameter int unsigned GQ_W   = PROD_W - GAIN_SHIFT;

   parameter logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(16384);
   parameter logic [SAMPLE_W-1:0] SAT_MAX    = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   parameter logic [SAMPLE_W-1:0] SAT_MIN    = {1'b1, {(SAMPLE_W - 1){1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SQR   = 6'b000010,
      ST_GAIN  = 6'b000100,
      ST_SAT   = 6'b001000,
      ST_LEVEL = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      LV_IDLE = 4'b0001,
      LV_DIV  = 4'b0010,
      LV_ROOT = 4'b0100,
      LV_DONE = 4'b1000
   } lv_state_type;

endpackage

>>> hdl/rmsg_level_unit.sv
// iterative mean and integer square root over one shared compare-subtract
module rmsg_level_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rmsg_pkg::SUM_W-1:0]       sum,
   input  logic [rmsg_pkg::CNT_W-1:0]       count,
   output logic                             done,
   output logic [rmsg_pkg::LEVEL_W-1:0]     level
);

   rmsg_pkg::lv_state_type                lv_state_ff, lv_state_in;
   logic [rmsg_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [rmsg_pkg::SUM_W-1:0]            dq_ff, dq_in;
   logic [rmsg_pkg::SUB_W-1:0]            rem_ff, rem_in;
   logic [rmsg_pkg::LEVEL_W-1:0]          root_ff, root_in;
   logic [rmsg_pkg::CNT_W-1:0]            div_ff, div_in;
   logic                                  zero_ff, zero_in;

   logic [rmsg_pkg::SUB_W-1:0]            sub_a, sub_b;
   logic [rmsg_pkg::SUB_W:0]              sub_diff;
   logic                                  sub_ge;

   // shared compare-subtract
   always_comb begin
      if (lv_state_ff == rmsg_pkg::LV_DIV) begin
         sub_a = rmsg_pkg::SUB_W'({rem_ff[rmsg_pkg::CNT_W-1:0], dq_ff[rmsg_pkg::SUM_W-1]});
         sub_b = rmsg_pkg::SUB_W'(div_ff);
      end else begin
         sub_a = {rem_ff[rmsg_pkg::SUB_W-3:0], dq_ff[rmsg_pkg::MEAN_W-1 -: 2]};
         sub_b = {root_ff, 2'b01};
      end
      sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
      sub_ge   = !sub_diff[rmsg_pkg::SUB_W];
   end

   always_comb begin
      lv_state_in = lv_state_ff;
      step_in     = step_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      div_in      = div_ff;
      zero_in     = zero_ff;
      unique case (lv_state_ff)
         rmsg_pkg::LV_IDLE: begin
            if (start) begin
               dq_in       = sum;
               div_in      = count;
               zero_in     = (count == '0);
               rem_in      = '0;
               step_in     = rmsg_pkg::STEP_W'(rmsg_pkg::SUM_W - 1);
               lv_state_in = rmsg_pkg::LV_DIV;
            end
         end
         rmsg_pkg::LV_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = sub_ge ? sub_diff[rmsg_pkg::SUB_W-1:0] : sub_a;
            dq_in  = {dq_ff[rmsg_pkg::SUM_W-2:0], sub_ge};
            step_in = step_ff - rmsg_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               rem_in      = '0;
               root_in     = '0;
               step_in     = rmsg_pkg::STEP_W'(rmsg_pkg::LEVEL_W - 1);
               lv_state_in = rmsg_pkg::LV_ROOT;
            end
         end
         rmsg_pkg::LV_ROOT: begin
            // digit-by-digit root, two radicand bits a cycle
            rem_in  = sub_ge ? sub_diff[rmsg_pkg::SUB_W-1:0] : sub_a;
            root_in = {root_ff[rmsg_pkg::LEVEL_W-2:0], sub_ge};
            dq_in   = {dq_ff[rmsg_pkg::SUM_W-3:0], 2'b00};
            step_in = step_ff - rmsg_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               lv_state_in = rmsg_pkg::LV_DONE;
            end
         end
         rmsg_pkg::LV_DONE: begin
            lv_state_in = rmsg_pkg::LV_IDLE;
         end
         default: begin
            lv_state_in = rmsg_pkg::LV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_state_ff <= rmsg_pkg::LV_IDLE;
      end else begin
         lv_state_ff <= lv_state_in;
      end
      step_ff <= step_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
      zero_ff <= zero_in;
   end

   assign done  = (lv_state_ff == rmsg_pkg::LV_DONE);
   assign level = zero_ff ? '0 : root_ff;

endmodule

>>> hdl/block_rms_meter_with_gain.sv
// top level of the block rms level meter with output gain
//
//  channel | direction | beat contents                                   | handshake
//  req     | in        | sample_in (s24 q1.23), last_in_block            | req_valid/req_ready
//  rsp     | out       | sample_out, level, level_new, block_end         | rsp_valid/rsp_ready
//  csr     | in        | volume_gain (u16 q2.14)                         | csr_valid/csr_ready
//
//  after a sample is accepted, one shared 25x25 multiplier gives the square, then the gained
//  product, then a saturate step and a result step; no new beat is taken until the result
//  has left the sequencer for the rsp register
//  a beat marked last adds a bit-serial divide and a two-bit-a-cycle root in the level
//  unit, both run on one compare-subtract
//  req_ready and csr_ready are high only while the sequencer is idle; a finished result
//  waits in the rsp register while the next beat is taken, and the sequencer holds its
//  result until that register frees up
//  synchronous active-high reset clears the sum, count, level, gain (to unity) and
//  the result valid flag, and returns both sequencers to idle
module block_rms_meter_with_gain (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rmsg_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                 req_last_in_block,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rmsg_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic [rmsg_pkg::LEVEL_W-1:0]         rsp_level,
   output logic                                 rsp_level_new,
   output logic                                 rsp_block_end,
   // gain register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rmsg_pkg::GAIN_W-1:0]          csr_volume_gain
);

   rmsg_pkg::state_type                    state_ff, state_in;
   logic [rmsg_pkg::SAMPLE_W-1:0]          sample_ff, sample_in;
   logic                                   last_ff, last_in;
   logic signed [rmsg_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [rmsg_pkg::SUM_W-1:0]             sum_ff, sum_in;
   logic [rmsg_pkg::CNT_W-1:0]             count_ff, count_in;
   logic [rmsg_pkg::GAIN_W-1:0]            gain_ff, gain_in;
   logic [rmsg_pkg::SAMPLE_W-1:0]          yout_ff, yout_in;
   logic [rmsg_pkg::LEVEL_W-1:0]           held_ff, held_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [rmsg_pkg::SAMPLE_W-1:0]          rsp_sample_ff, rsp_sample_in;
   logic [rmsg_pkg::LEVEL_W-1:0]           rsp_level_ff, rsp_level_in;
   logic                                   rsp_last_ff, rsp_last_in;

   // shared multiplier
   logic signed [rmsg_pkg::MUL_W-1:0]      mul_a, mul_b;
   logic signed [rmsg_pkg::PROD_W-1:0]     mul_p;

   // gain scaling and clamp
   logic [rmsg_pkg::GQ_W-1:0]              gain_q;
   logic                                   sat_hi, sat_lo;

   logic                                   lvl_start, lvl_done;
   logic [rmsg_pkg::LEVEL_W-1:0]           lvl_level;
   logic                                   rsp_load;

   // operand a is always the sample; operand b is the sample again for the square,
   // the zero-extended gain for the output product
   assign mul_a = $signed({sample_ff[rmsg_pkg::SAMPLE_W-1], sample_ff});
   assign mul_b = (state_ff == rmsg_pkg::ST_SQR) ? mul_a :
                  $signed({{(rmsg_pkg::MUL_W - rmsg_pkg::GAIN_W){1'b0}}, gain_ff});
   assign mul_p = mul_a * mul_b;

   // arithmetic drop of the fraction bits rounds toward minus infinity
   assign gain_q = prod_ff[rmsg_pkg::PROD_W-1:rmsg_pkg::GAIN_SHIFT];
   assign sat_hi = !gain_q[rmsg_pkg::GQ_W-1] &&
                   (|gain_q[rmsg_pkg::GQ_W-2:rmsg_pkg::SAMPLE_W-1]);
   assign sat_lo = gain_q[rmsg_pkg::GQ_W-1] &&
                   !(&gain_q[rmsg_pkg::GQ_W-2:rmsg_pkg::SAMPLE_W-1]);

   // result register is free when empty or being drained this cycle
   assign rsp_load  = (state_ff == rmsg_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign lvl_start = (state_ff == rmsg_pkg::ST_SAT) && last_ff;

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      last_in   = last_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      yout_in   = yout_ff;
      held_in   = held_ff;
      unique case (state_ff)
         rmsg_pkg::ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample_in;
               last_in   = req_last_in_block;
               state_in  = rmsg_pkg::ST_SQR;
            end
         end
         rmsg_pkg::ST_SQR: begin
            prod_in  = mul_p;
            state_in = rmsg_pkg::ST_GAIN;
         end
         rmsg_pkg::ST_GAIN: begin
            // prod_ff still holds the square here; a full block stops accumulating
            prod_in = mul_p;
            if (count_ff < rmsg_pkg::CNT_W'(rmsg_pkg::MAX_BLOCK_SAMPLES)) begin
               sum_in   = sum_ff + rmsg_pkg::SUM_W'(prod_ff[rmsg_pkg::SQ_W-1:0]);
               count_in = count_ff + rmsg_pkg::CNT_W'(1);
            end
            state_in = rmsg_pkg::ST_SAT;
         end
         rmsg_pkg::ST_SAT: begin
            if (sat_hi) begin
               yout_in = rmsg_pkg::SAT_MAX;
            end else if (sat_lo) begin
               yout_in = rmsg_pkg::SAT_MIN;
            end else begin
               yout_in = gain_q[rmsg_pkg::SAMPLE_W-1:0];
            end
            if (last_ff) begin
               // level unit latches sum and count this cycle
               sum_in   = '0;
               count_in = '0;
               state_in = rmsg_pkg::ST_LEVEL;
            end else begin
               state_in = rmsg_pkg::ST_DONE;
            end
         end
         rmsg_pkg::ST_LEVEL: begin
            if (lvl_done) begin
               held_in  = lvl_level;
               state_in = rmsg_pkg::ST_DONE;
            end
         end
         rmsg_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = rmsg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmsg_pkg::ST_IDLE;
         end
      endcase
   end

   // gain register, written only while idle
   always_comb begin
      gain_in = gain_ff;
      if (csr_valid && csr_ready) begin
         gain_in = csr_volume_gain;
      end
   end

   // result register
   always_comb begin
      rsp_sample_in = rsp_sample_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_sample_in = yout_ff;
         rsp_level_in  = held_ff;
         rsp_last_in   = last_ff;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmsg_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         gain_ff      <= rmsg_pkg::GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      yout_ff       <= yout_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // mean and root of the finished block
   rmsg_level_unit u_level (
      .clock (clock),
      .reset (reset),
      .start (lvl_start),
      .sum   (sum_ff),
      .count (count_ff),
      .done  (lvl_done),
      .level (lvl_level)
   );

   assign req_ready      = (state_ff == rmsg_pkg::ST_IDLE);
   assign csr_ready      = (state_ff == rmsg_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = $signed(rsp_sample_ff);
   assign rsp_level      = rsp_level_ff;
   assign rsp_level_new  = rsp_last_ff;
   assign rsp_block_end  = rsp_last_ff;

endmodule

>>> hdl/rmsg_checker.sv
// port-level checks of the rms level meter, bound to the top level
`include "assert_macros.svh"

module rmsg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [rmsg_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input logic [rmsg_pkg::LEVEL_W-1:0]         rsp_level,
   input logic                                 rsp_level_new,
   input logic                                 rsp_block_end
);

   // one beat at a time: the sequencer is busy right after a take
   `RMSG_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // a new level is reported exactly on block ends
   `RMSG_ASSERT_NOW(a_new_on_end, clock, reset, rsp_valid, rsp_level_new == rsp_block_end)

   // an rms of a q1.23 signal never passes full scale
   `RMSG_ASSERT_NOW(a_level_range, clock, reset, rsp_valid,
                    rsp_level <= rmsg_pkg::LEVEL_W'(8388608))

   // a stalled result holds
   `RMSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_sample_out) && $stable(rsp_level))

endmodule

bind block_rms_meter_with_gain rmsg_checker u_rmsg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_level      (rsp_level),
   .rsp_level_new  (rsp_level_new),
   .rsp_block_end  (rsp_block_end)
);

>>> tb/testbench.sv
// self-checking testbench of the block rms level meter with output gain
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // run limits
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 1450;
   localparam int unsigned QUIET_ITEMS  = 150;

   // sample values at the edges of q1.23
   localparam logic [rmsg_pkg::SAMPLE_W-1:0] FULL_POS  = rmsg_pkg::SAT_MAX;
   localparam logic [rmsg_pkg::SAMPLE_W-1:0] FULL_NEG  = rmsg_pkg::SAT_MIN;
   localparam logic [rmsg_pkg::SAMPLE_W-1:0] MINUS_ONE = 24'hFFFFFF;
   localparam logic [rmsg_pkg::GAIN_W-1:0]   GAIN_ZERO = 16'h0000;
   localparam logic [rmsg_pkg::GAIN_W-1:0]   GAIN_TOP  = 16'hFFFF;

   // one result beat as it leaves the block
   typedef struct packed {
      logic signed [rmsg_pkg::SAMPLE_W-1:0] sample_out;
      logic [rmsg_pkg::LEVEL_W-1:0]         level;
      logic                                 level_new;
      logic                                 block_end;
   } meter_result_type;

   // one row of the directed table; gain is written before the row when set_gain is high,
   // and want is used in place of the prediction when typed is high
   typedef struct packed {
      logic                          set_gain;
      logic [rmsg_pkg::GAIN_W-1:0]   gain;
      logic [rmsg_pkg::SAMPLE_W-1:0] sample;
      logic                          last;
      logic                          typed;
      meter_result_type              want;
   } directed_row_type;

   localparam int unsigned DIRECTED_ROWS = 23;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // silent one-sample block straight after reset
      '{1'b0, GAIN_ZERO, 24'h000000, 1'b1, 1'b1, '{24'h000000, 24'd0, 1'b1, 1'b1}},
      // unity gain passes the extremes through, level still zero
      '{1'b0, GAIN_ZERO, FULL_POS,   1'b0, 1'b1, '{FULL_POS,   24'd0, 1'b0, 1'b0}},
      '{1'b0, GAIN_ZERO, FULL_NEG,   1'b0, 1'b1, '{FULL_NEG,   24'd0, 1'b0, 1'b0}},
      '{1'b0, GAIN_ZERO, MINUS_ONE,  1'b0, 1'b1, '{MINUS_ONE,  24'd0, 1'b0, 1'b0}},
      '{1'b0, GAIN_ZERO, 24'h000001, 1'b1, 1'b0, '0},
      // full-scale negative block gives the top level 2^23
      '{1'b0, GAIN_ZERO, FULL_NEG,   1'b1, 1'b1, '{FULL_NEG,   24'h800000, 1'b1, 1'b1}},
      '{1'b0, GAIN_ZERO, FULL_POS,   1'b1, 1'b1, '{FULL_POS,   24'h7FFFFF, 1'b1, 1'b1}},
      // level holds mid-block, then mean of 9 and 16 floors to 12, root 3
      '{1'b0, GAIN_ZERO, 24'd3,      1'b0, 1'b1, '{24'd3,      24'h7FFFFF, 1'b0, 1'b0}},
      '{1'b0, GAIN_ZERO, 24'd4,      1'b1, 1'b1, '{24'd4,      24'd3, 1'b1, 1'b1}},
      // zero gain mutes the output but not the meter
      '{1'b1, GAIN_ZERO, 24'hFFFFFB, 1'b1, 1'b1, '{24'h000000, 24'd5, 1'b1, 1'b1}},
      '{1'b0, GAIN_ZERO, FULL_POS,   1'b0, 1'b1, '{24'h000000, 24'd5, 1'b0, 1'b0}},
      '{1'b0, GAIN_ZERO, 24'h555555, 1'b1, 1'b0, '0},
      // top gain: 1 -> 3, -1 rounds toward minus infinity to -4, full scale saturates
      '{1'b1, GAIN_TOP,  24'h000001, 1'b1, 1'b1, '{24'd3,      24'd1, 1'b1, 1'b1}},
      '{1'b0, GAIN_ZERO, MINUS_ONE,  1'b0, 1'b1, '{24'hFFFFFC, 24'd1, 1'b0, 1'b0}},
      '{1'b0, GAIN_ZERO, FULL_POS,   1'b0, 1'b1, '{FULL_POS,   24'd1, 1'b0, 1'b0}},
      '{1'b0, GAIN_ZERO, FULL_NEG,   1'b1, 1'b0, '0},
      '{1'b0, GAIN_ZERO, 24'hAAAAAA, 1'b1, 1'b0, '0},
      // gain of two: positive half scale clips, negative half scale lands exactly on min
      '{1'b1, 16'h8000,  24'h400000, 1'b0, 1'b0, '0},
      '{1'b0, GAIN_ZERO, 24'hC00000, 1'b1, 1'b0, '0},
      '{1'b1, 16'hAAAA,  24'h2AAAAA, 1'b1, 1'b0, '0},
      '{1'b1, 16'h5555,  24'hD55555, 1'b1, 1'b0, '0},
      // just above unity
      '{1'b1, 16'h4001,  24'h7FFFFE, 1'b0, 1'b0, '0},
      '{1'b1, rmsg_pkg::GAIN_RESET, 24'h123456, 1'b1, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [rmsg_pkg::SAMPLE_W-1:0] req_sample_in = '0;
   logic                                 req_last_in_block = 1'b0;

   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [rmsg_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic [rmsg_pkg::LEVEL_W-1:0]         rsp_level;
   logic                                 rsp_level_new;
   logic                                 rsp_block_end;

   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [rmsg_pkg::GAIN_W-1:0]          csr_volume_gain = '0;

   // meter state as the predictor sees it
   longint unsigned              sq_sum = 0;
   int unsigned                  sq_count = 0;
   logic [rmsg_pkg::LEVEL_W-1:0] level_hold = '0;
   logic [rmsg_pkg::GAIN_W-1:0]  gain_now = rmsg_pkg::GAIN_RESET;

   meter_result_type result_due[$];
   meter_result_type oldest;
   int unsigned   items_sent = 0;
   int unsigned   mismatches = 0;
   int unsigned   cycle_count = 0;
   int unsigned   stall_left = 0;
   // when low, neither side idles
   bit            noisy = 1'b1;

   block_rms_meter_with_gain u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .req_last_in_block (req_last_in_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_level         (rsp_level),
      .rsp_level_new     (rsp_level_new),
      .rsp_block_end     (rsp_block_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_volume_gain   (csr_volume_gain)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor of the square root, built one result bit at a time from the top;
   // the mean never exceeds 2^46, so 24 result bits are enough
   function automatic logic [rmsg_pkg::LEVEL_W-1:0] floor_root(input longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = rmsg_pkg::LEVEL_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x)
            root = trial;
      end
      return root[rmsg_pkg::LEVEL_W-1:0];
   endfunction

   // advance the meter state by one accepted sample and return the result it owes
   function automatic meter_result_type meter_predict(
      input logic signed [rmsg_pkg::SAMPLE_W-1:0] s, input logic last);
      meter_result_type r;
      longint signed prod;
      longint signed scaled;
      // the accumulator freezes once the block holds the maximum count
      if (sq_count < rmsg_pkg::MAX_BLOCK_SAMPLES) begin
         sq_sum   = sq_sum + longint'(s) * longint'(s);
         sq_count = sq_count + 1;
      end
      // q1.23 times unsigned q2.14; arithmetic shift floors toward minus infinity
      prod   = longint'(s) * longint'(gain_now);
      scaled = prod >>> rmsg_pkg::GAIN_SHIFT;
      if (scaled > longint'(signed'(rmsg_pkg::SAT_MAX)))
         scaled = longint'(signed'(rmsg_pkg::SAT_MAX));
      if (scaled < longint'(signed'(rmsg_pkg::SAT_MIN)))
         scaled = longint'(signed'(rmsg_pkg::SAT_MIN));
      if (last) begin
         level_hold = (sq_count != 0) ? floor_root(sq_sum / sq_count) : '0;
         sq_sum     = 0;
         sq_count   = 0;
      end
      r.sample_out = scaled[rmsg_pkg::SAMPLE_W-1:0];
      r.level      = level_hold;
      r.level_new  = last;
      r.block_end  = last;
      return r;
   endfunction

   // mostly full-range noise, some extremes and values near zero; loud mode mostly extremes
   function automatic logic [rmsg_pkg::SAMPLE_W-1:0] pick_sample(input bit loud);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (loud && pick < 7)
         return ($urandom_range(0, 1) != 0) ? FULL_POS : FULL_NEG;
      case (pick) inside
         0:       return FULL_POS;
         1:       return FULL_NEG;
         [2:3]:   return rmsg_pkg::SAMPLE_W'($urandom_range(0, 511)) -
                         rmsg_pkg::SAMPLE_W'(256);
         default: return rmsg_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [rmsg_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return GAIN_ZERO;
         1:       return GAIN_TOP;
         2:       return rmsg_pkg::GAIN_RESET;
         3:       return rmsg_pkg::GAIN_W'($urandom_range(15000, 18000));
         default: return rmsg_pkg::GAIN_W'($urandom);
      endcase
   endfunction

   // offer one sample beat; called at a falling edge, returns at the falling edge after
   // the accept with req_valid still high, so the next beat can follow back to back
   task automatic play_sample(input logic [rmsg_pkg::SAMPLE_W-1:0] s, input logic last,
                              input logic typed, input meter_result_type want);
      meter_result_type predicted;
      if (noisy && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_sample_in     = s;
      req_last_in_block = last;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = meter_predict(s, last);
      result_due.push_back(typed ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic play_block(input int unsigned len, input bit loud);
      for (int unsigned k = 0; k < len; k++)
         play_sample(pick_sample(loud), k == len - 1, 1'b0, '0);
   endtask

   // hold off the sender until every owed result is back and the block sits idle
   task automatic drain_results();
      req_valid = 1'b0;
      while (result_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // gain writes only happen with the block idle
   task automatic write_gain(input logic [rmsg_pkg::GAIN_W-1:0] g);
      drain_results();
      csr_volume_gain = g;
      csr_valid       = 1'b1;
      do @(posedge clock); while (!csr_ready);
      gain_now = g;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic check_field(input string what, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // result side: random stall bursts while noisy, always ready otherwise
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  = 1'b0;
         stall_left = stall_left - 1;
      end else if (noisy && !reset && $urandom_range(0, 5) == 0) begin
         rsp_ready  = 1'b0;
         stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // compare each accepted result beat with the oldest owed result
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_due.size() == 0) begin
            mismatches++;
            $display("%0t ns: result beat with nothing owed, expected none, got %0d",
                     $time, rsp_sample_out);
         end else begin
            oldest = result_due.pop_front();
            check_field("sample_out", oldest.sample_out, rsp_sample_out);
            check_field("level", oldest.level, rsp_level);
            check_field("level_new", oldest.level_new, rsp_level_new);
            check_field("block_end", oldest.block_end, rsp_block_end);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned quiet_from;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, starting from the reset gain
      for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].set_gain)
            write_gain(DIRECTED[i].gain);
         play_sample(DIRECTED[i].sample, DIRECTED[i].last, DIRECTED[i].typed,
                     DIRECTED[i].want);
      end

      // random blocks, mostly short, with the odd long or loud one and gain changes
      // between them; loud content pushes the squares toward their top
      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0)
            write_gain(pick_gain());
         noisy = ($urandom_range(0, 3) != 0);
         play_block(($urandom_range(0, 7) == 0) ? $urandom_range(25, 300)
                                                 : $urandom_range(1, 24),
                    $urandom_range(0, 7) == 0);
      end

      // closing stretch with neither side idling
      noisy      = 1'b0;
      quiet_from = items_sent;
      while (items_sent < quiet_from + QUIET_ITEMS)
         play_block($urandom_range(1, 24), 1'b0);

      // wait out the owed results, then long enough for a stray beat to show
      req_valid = 1'b0;
      while (result_due.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
